// ----- rtl/tpet_pkg.sv -----
// ---------------------------------------------------------------------------
// tpet_pkg: shared types and constants for the pattern event transcoder
// Request/result payloads, queue entry layout and the effect remap function.
// ---------------------------------------------------------------------------
`default_nettype none

package tpet_pkg;

   // Default depth of the queue between the parser and the byte emitter
   localparam int QUEUE_DEPTH = 4;

   // Header bits and masks
   localparam logic [4:0] CHAN_MASK    = 5'h1F;
   localparam logic [4:0] FX_VOLUME    = 5'h0C;
   localparam logic [7:0] PARAM_CLAMP  = 8'hDF;
   localparam logic [7:0] PARAM_LIMIT  = 8'hE0;
   localparam logic [3:0] EXT_FINEVOL  = 4'hA;
   localparam logic [3:0] PAN_SUB      = 4'h8;
   localparam logic [7:0] PAN_BASE     = 8'h80;

   // Source effect numbers (low five bits)
   localparam logic [4:0] SRC_NONE     = 5'h00;
   localparam logic [4:0] SRC_PORTUP   = 5'h01;
   localparam logic [4:0] SRC_PORTDN   = 5'h02;
   localparam logic [4:0] SRC_TONEPORT = 5'h03;
   localparam logic [4:0] SRC_VIBRATO  = 5'h04;
   localparam logic [4:0] SRC_TPVOL    = 5'h05;
   localparam logic [4:0] SRC_VIBVOL   = 5'h06;
   localparam logic [4:0] SRC_TREMOLO  = 5'h07;
   localparam logic [4:0] SRC_TREMOR   = 5'h08;
   localparam logic [4:0] SRC_OFFSET   = 5'h09;
   localparam logic [4:0] SRC_VOLSLIDE = 5'h0A;
   localparam logic [4:0] SRC_JUMP     = 5'h0B;
   localparam logic [4:0] SRC_BREAK    = 5'h0D;
   localparam logic [4:0] SRC_EXT      = 5'h0E;
   localparam logic [4:0] SRC_SPEED    = 5'h0F;
   localparam logic [4:0] SRC_ARP      = 5'h10;
   localparam logic [4:0] SRC_CHANGE   = 5'h11;
   localparam logic [4:0] SRC_RETRIG   = 5'h12;
   localparam logic [4:0] SRC_GVOL     = 5'h13;
   localparam logic [4:0] SRC_FINEVIB  = 5'h14;
   localparam logic [4:0] SRC_SPECIAL  = 5'h1E;
   localparam logic [4:0] SRC_TEMPO    = 5'h1F;

   // Target effect codes
   localparam logic [4:0] FX_NONE = 5'd0;
   localparam logic [4:0] FX_A    = 5'd1;
   localparam logic [4:0] FX_B    = 5'd2;
   localparam logic [4:0] FX_C    = 5'd3;
   localparam logic [4:0] FX_D    = 5'd4;
   localparam logic [4:0] FX_E    = 5'd5;
   localparam logic [4:0] FX_F    = 5'd6;
   localparam logic [4:0] FX_G    = 5'd7;
   localparam logic [4:0] FX_H    = 5'd8;
   localparam logic [4:0] FX_I    = 5'd9;
   localparam logic [4:0] FX_J    = 5'd10;
   localparam logic [4:0] FX_K    = 5'd11;
   localparam logic [4:0] FX_L    = 5'd12;
   localparam logic [4:0] FX_O    = 5'd15;
   localparam logic [4:0] FX_Q    = 5'd17;
   localparam logic [4:0] FX_R    = 5'd18;
   localparam logic [4:0] FX_S    = 5'd19;
   localparam logic [4:0] FX_T    = 5'd20;
   localparam logic [4:0] FX_U    = 5'd21;
   localparam logic [4:0] FX_V    = 5'd22;

   // Extended sub-effect tables, indexed by the param's high nibble
   localparam logic [4:0] EXT_FX [16] = '{
      FX_S, FX_F, FX_E, FX_S, FX_S, FX_S, FX_S, FX_S,
      FX_F, FX_E, FX_D, FX_D, FX_S, FX_S, FX_S, FX_S
   };
   localparam logic [7:0] EXT_BASE [16] = '{
      8'h00, 8'hF0, 8'hF0, 8'h10, 8'h30, 8'h20, 8'hB0, 8'h40,
      8'hE0, 8'hE0, 8'h0F, 8'hF0, 8'hC0, 8'hD0, 8'hE0, 8'hF0
   };

   // Request and result payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       pattern_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       pattern_done;
   } rsp_type;

   // One queue entry: an optional event and an optional trailing header byte
   typedef struct packed {
      logic       evt_valid;
      logic [4:0] evt_chan;
      logic       has_note;
      logic       has_vol;
      logic       has_eff;
      logic [7:0] note;
      logic [7:0] sample;
      logic [7:0] vol;
      logic [4:0] eff;
      logic [7:0] param;
      logic       extra_valid;
      logic [4:0] extra_chan;
      logic       done;
   } qentry_type;

   typedef struct packed {
      logic [4:0] eff;
      logic [7:0] param;
   } remap_type;

   // Map a source effect and its param onto the target effect set
   function automatic remap_type remap_effect(input logic [4:0] fx, input logic [7:0] p);
      remap_type  r;
      logic [3:0] hi;
      logic [3:0] lo;
      hi = p[7:4];
      lo = p[3:0];
      r.eff   = FX_NONE;
      r.param = p;
      unique case (fx)
         SRC_NONE:     r.eff = FX_NONE;
         SRC_PORTUP: begin
            r.eff = FX_F;
            if (p >= PARAM_LIMIT) r.param = PARAM_CLAMP;
         end
         SRC_PORTDN: begin
            r.eff = FX_E;
            if (p >= PARAM_LIMIT) r.param = PARAM_CLAMP;
         end
         SRC_TONEPORT: r.eff = FX_G;
         SRC_VIBRATO:  r.eff = FX_H;
         SRC_TPVOL:    r.eff = FX_L;
         SRC_VIBVOL:   r.eff = FX_K;
         SRC_TREMOLO:  r.eff = FX_R;
         SRC_TREMOR:   r.eff = FX_I;
         SRC_OFFSET:   r.eff = FX_O;
         SRC_VOLSLIDE: r.eff = FX_D;
         SRC_JUMP:     r.eff = FX_B;
         SRC_BREAK:    r.eff = FX_C;
         SRC_EXT: begin
            r.eff = EXT_FX[hi];
            if (hi == EXT_FINEVOL) r.param = {lo, 4'hF};
            else r.param = 8'(EXT_BASE[hi] + {4'b0, lo});
         end
         SRC_SPEED:    r.eff = FX_A;
         SRC_ARP:      r.eff = FX_J;
         SRC_CHANGE:   r.eff = FX_NONE;
         SRC_RETRIG:   r.eff = FX_Q;
         SRC_GVOL:     r.eff = FX_V;
         SRC_FINEVIB:  r.eff = FX_U;
         SRC_SPECIAL: begin
            if (hi == PAN_SUB) begin
               r.eff   = FX_S;
               r.param = PAN_BASE + {4'b0, lo};
            end else begin
               r.eff = FX_NONE;
            end
         end
         SRC_TEMPO:    r.eff = FX_T;
         default: begin
            // volume number and unassigned numbers map to nothing
            r.eff   = FX_NONE;
            r.param = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tpet_front.sv -----
// ---------------------------------------------------------------------------
// tpet_front: pattern byte parser
// Accepts one source byte per cycle while accept is high, tracks the event being
// assembled and pushes finished events (plus any trailing header byte) into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tpet_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire tpet_pkg::req_type    req_data,
   output logic                      q_push,
   output tpet_pkg::qentry_type      q_entry
);

   typedef enum logic [4:0] {
      PH_WAIT    = 5'b00001,
      PH_NOTE    = 5'b00010,
      PH_SAMPLE  = 5'b00100,
      PH_FXNUM   = 5'b01000,
      PH_FXPARAM = 5'b10000
   } phase_type;

   typedef struct packed {
      logic note;
      logic fx_flag;
      logic vol;
      logic eff;
   } flags_type;

   // Control state
   phase_type  phase_ff, phase_in;
   flags_type  flags_ff, flags_in, flags_upd;
   logic [4:0] chan_ff, chan_in;
   logic [5:0] held_ff, held_in;

   // Event payload
   logic [7:0] note_ff, note_in;
   logic [7:0] sample_ff, sample_in;
   logic [7:0] vol_ff, vol_in;
   logic [4:0] eff_ff, eff_in;
   logic [7:0] param_ff, param_in;

   logic       close, take_hdr, conflict, hdr_emit, is_vol, end_i;
   logic [7:0] x;
   tpet_pkg::remap_type mapped;

   assign x        = req_data.in_byte;
   assign end_i    = req_data.pattern_end;
   assign is_vol   = (x[4:0] == tpet_pkg::FX_VOLUME);
   assign mapped   = tpet_pkg::remap_effect(held_ff[4:0], x);
   // a header byte goes out at once at pattern end or if it opens no part
   assign hdr_emit = (x == 8'h00) || !(x[5] || x[6]) || end_i;

   // Phase step
   always_comb begin
      phase_in  = phase_ff;
      flags_upd = flags_ff;
      chan_in   = chan_ff;
      held_in   = held_ff;
      note_in   = note_ff;
      sample_in = sample_ff;
      vol_in    = vol_ff;
      eff_in    = eff_ff;
      param_in  = param_ff;
      close     = 1'b0;
      take_hdr  = 1'b0;
      conflict  = 1'b0;
      unique case (phase_ff)
         PH_NOTE: begin
            note_in  = 8'({1'b0, x[6:0]} - 8'd1);
            phase_in = PH_SAMPLE;
         end
         PH_SAMPLE: begin
            sample_in      = x;
            flags_upd.note = 1'b1;
            if (flags_ff.fx_flag) phase_in = PH_FXNUM;
            else close = 1'b1;
         end
         PH_FXNUM: begin
            if (is_vol ? flags_ff.vol : flags_ff.eff) begin
               // second effect of a kind: close and reread as header
               close    = 1'b1;
               take_hdr = 1'b1;
               conflict = 1'b1;
            end else begin
               held_in  = x[5:0];
               phase_in = PH_FXPARAM;
            end
         end
         PH_FXPARAM: begin
            if (held_ff[4:0] == tpet_pkg::FX_VOLUME) begin
               flags_upd.vol = 1'b1;
               vol_in        = x;
            end else begin
               flags_upd.eff = 1'b1;
               eff_in        = mapped.eff;
               param_in      = mapped.param;
            end
            if (held_ff[5]) phase_in = PH_FXNUM;
            else close = 1'b1;
         end
         default: take_hdr = 1'b1;
      endcase

      // next control state after close, header and pattern end
      flags_in = flags_upd;
      if (close) begin
         flags_in = '0;
         phase_in = PH_WAIT;
      end
      if (take_hdr) begin
         chan_in          = x[4:0];
         flags_in         = '0;
         flags_in.fx_flag = x[6];
         if (x == 8'h00)  phase_in = PH_WAIT;
         else if (x[5])   phase_in = PH_NOTE;
         else if (x[6])   phase_in = PH_FXNUM;
         else             phase_in = PH_WAIT;
      end
      if (end_i) begin
         phase_in = PH_WAIT;
         flags_in = '0;
      end
   end

   // Queue entry
   always_comb begin
      q_entry.evt_chan    = chan_ff;
      q_entry.has_note    = flags_upd.note;
      q_entry.has_vol     = flags_upd.vol;
      q_entry.has_eff     = flags_upd.eff;
      q_entry.note        = note_in;
      q_entry.sample      = sample_in;
      q_entry.vol         = vol_in;
      q_entry.eff         = eff_in;
      q_entry.param       = param_in;
      q_entry.extra_chan  = x[4:0];
      q_entry.done        = end_i;
      if (take_hdr && !conflict) begin
         q_entry.evt_valid   = hdr_emit;
         q_entry.evt_chan    = x[4:0];
         q_entry.has_note    = 1'b0;
         q_entry.has_vol     = 1'b0;
         q_entry.has_eff     = 1'b0;
         q_entry.extra_valid = 1'b0;
      end else begin
         q_entry.evt_valid   = close || end_i;
         q_entry.extra_valid = take_hdr && hdr_emit;
      end
   end

   assign q_push = accept && (q_entry.evt_valid || q_entry.extra_valid);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         flags_ff <= '0;
         chan_ff  <= '0;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         chan_ff  <= chan_in;
         held_ff  <= held_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         note_ff   <= note_in;
         sample_ff <= sample_in;
         vol_ff    <= vol_in;
         eff_ff    <= eff_in;
         param_ff  <= param_in;
      end
   end

   // Held parts only exist while effect pairs are being read
   a_held_in_fx: assert property (@(posedge clock) disable iff (reset)
      (flags_ff.note || flags_ff.vol || flags_ff.eff)
         |-> (phase_ff == PH_FXNUM || phase_ff == PH_FXPARAM))
      else $error("held event part outside effect phases");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && end_i) |=> (phase_ff == PH_WAIT && flags_ff == '0))
      else $error("parser not idle after pattern end");

endmodule

`default_nettype wire

// ----- rtl/tpet_fifo.sv -----
// ---------------------------------------------------------------------------
// tpet_fifo: event queue
// Short queue of parsed events between the parser and the byte emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module tpet_fifo #(
   parameter int DEPTH = tpet_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire tpet_pkg::qentry_type wr_data,
   output logic                      full,
   input  wire logic                 rd_en,
   output tpet_pkg::qentry_type      rd_data,
   output logic                      empty
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   tpet_pkg::qentry_type store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == CountWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) store_ff[wr_ptr_ff] <= wr_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue fill count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count missed a write");

endmodule

`default_nettype wire

// ----- rtl/tpet_back.sv -----
// ---------------------------------------------------------------------------
// tpet_back: byte emitter
// Takes queued events and writes their output bytes one per cycle into the
// result register while it is free or popped, and marks each request's last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tpet_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpet_pkg::qentry_type q_head,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   output logic                      empty,
   input  wire logic                 pop,
   output tpet_pkg::rsp_type         rsp_data
);

   // slot order: header, note, sample, volume, effect, param, trailing header
   localparam int Slots = 7;

   tpet_pkg::qentry_type cur_ff, cur_in;
   logic [Slots-1:0]     rem_ff, rem_in, rem_after, low;
   logic                 out_valid_ff, out_valid_in;
   tpet_pkg::rsp_type    out_ff, out_in;
   logic                 advance, emit;
   logic [7:0]           byte_sel;
   logic [Slots-1:0]     head_mask;

   // Slots present in the queue head
   assign head_mask = {q_head.extra_valid,
                       q_head.has_eff, q_head.has_eff,
                       q_head.has_vol,
                       q_head.has_note, q_head.has_note,
                       q_head.evt_valid};

   assign advance   = !out_valid_ff || pop;
   assign emit      = advance && (rem_ff != '0);
   assign low       = rem_ff & (~rem_ff + 1'b1);
   assign rem_after = emit ? (rem_ff & ~low) : rem_ff;
   assign q_pop     = (rem_after == '0) && !q_empty;

   // Byte for the lowest pending slot
   always_comb begin
      priority if (rem_ff[0])
         byte_sel = {cur_ff.has_eff, cur_ff.has_vol, cur_ff.has_note, cur_ff.evt_chan};
      else if (rem_ff[1]) byte_sel = cur_ff.note;
      else if (rem_ff[2]) byte_sel = cur_ff.sample;
      else if (rem_ff[3]) byte_sel = cur_ff.vol;
      else if (rem_ff[4]) byte_sel = {3'b000, cur_ff.eff};
      else if (rem_ff[5]) byte_sel = cur_ff.param;
      else                byte_sel = {3'b000, cur_ff.extra_chan};
   end

   // Next entry, slot mask and result register
   always_comb begin
      cur_in       = cur_ff;
      rem_in       = rem_after;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         cur_in = q_head;
         rem_in = head_mask;
      end
      if (emit) begin
         out_valid_in        = 1'b1;
         out_in.out_byte     = byte_sel;
         out_in.run_last     = (rem_after == '0);
         out_in.pattern_done = (rem_after == '0) && cur_ff.done;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   // the next entry is taken only once the current one has nothing left to send
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((rem_ff != '0) && !emit) |-> !q_pop)
      else $error("queue popped while an event is still being sent");

endmodule

`default_nettype wire

// ----- rtl/tracker_pattern_event_transcoder.sv -----
// ---------------------------------------------------------------------------
// tracker_pattern_event_transcoder: packed pattern byte stream converter
// Parses packed source pattern events byte by byte and emits the packed
// target pattern bytes, remapping effects on the way.
// ---------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  request   in         push / full       req_payload : in_byte, pattern_end
//  result    out        pop / empty       rsp_payload : out_byte, run_last,
//                                                       pattern_done
//
//  One request is taken per cycle while the event queue has room; the parser
//  finishes its work on the request in that cycle.
//  Result bytes leave the output register at one per cycle while pop is held;
//  a request yields zero to seven bytes.
//  full rises when QUEUE_DEPTH parsed events wait for the emitter.
//  Synchronous active-high reset clears parser, queue and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tracker_pattern_event_transcoder #(
   parameter int QUEUE_DEPTH = tpet_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire tpet_pkg::req_type req_payload,
   output logic                   empty,
   input  wire logic              pop,
   output tpet_pkg::rsp_type      rsp_payload
);

   logic                 accept;
   logic                 q_push, q_pop, q_full, q_empty;
   tpet_pkg::qentry_type q_entry, q_head;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Parser
   tpet_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_payload),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Event queue
   tpet_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_entry),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   // Byte emitter
   tpet_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_payload)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.pattern_done) |-> rsp_payload.run_last)
      else $error("pattern end marked on a byte that does not close its request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result shown straight after reset");

endmodule

`default_nettype wire

// ----- tb/tb_tpet_scoreboard_pkg.sv -----
// ---------------------------------------------------------------------------
// tb_tpet_scoreboard_pkg: result scoreboard for the pattern event transcoder
// Predicts the packed target bytes for each accepted request from a local
// copy of the parser state, and checks the result bytes against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package tb_tpet_scoreboard_pkg;

   import tpet_pkg::*;

   // Source header and effect number bits
   localparam logic [7:0] IN_NOTE_FLAG   = 8'h20;
   localparam logic [7:0] IN_EFFECT_FLAG = 8'h40;
   localparam logic [7:0] CHAIN_FLAG     = 8'h20;

   // Target header bits
   localparam logic [7:0] OUT_NOTE_BIT   = 8'h20;
   localparam logic [7:0] OUT_VOL_BIT    = 8'h40;
   localparam logic [7:0] OUT_EFF_BIT    = 8'h80;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_NOTE     = 3'd1,
      PH_SAMPLE   = 3'd2,
      PH_FX_NUM   = 3'd3,
      PH_FX_PARAM = 3'd4
   } parse_phase_e;

   class event_transcode_scoreboard;

      parse_phase_e phase;
      logic [4:0]   chan;
      logic [7:0]   note_byte;
      logic [7:0]   sample_byte;
      logic [7:0]   vol_byte;
      logic [7:0]   fx_number;
      logic [7:0]   eff_byte;
      logic [7:0]   param_byte;
      bit           note_held;
      bit           fx_flagged;
      bit           vol_held;
      bit           eff_held;
      rsp_type      expected_bytes[$];
      rsp_type      step_bytes[$];
      int           mismatch_count;

      function new();
         phase          = PH_HEADER;
         chan           = '0;
         note_byte      = '0;
         sample_byte    = '0;
         vol_byte       = '0;
         fx_number      = '0;
         eff_byte       = '0;
         param_byte     = '0;
         note_held      = 1'b0;
         fx_flagged     = 1'b0;
         vol_held       = 1'b0;
         eff_held       = 1'b0;
         mismatch_count = 0;
      endfunction

      function int outstanding();
         return expected_bytes.size();
      endfunction

      function void clear_flags();
         note_held  = 1'b0;
         fx_flagged = 1'b0;
         vol_held   = 1'b0;
         eff_held   = 1'b0;
      endfunction

      function void emit(logic [7:0] b);
         rsp_type e;
         e.out_byte     = b;
         e.run_last     = 1'b0;
         e.pattern_done = 1'b0;
         step_bytes.push_back(e);
      endfunction

      // Write out the held event: header, note pair, volume, effect pair
      function void close_event();
         logic [7:0] hdr;
         hdr = {3'b000, chan};
         if (note_held) hdr |= OUT_NOTE_BIT;
         if (vol_held)  hdr |= OUT_VOL_BIT;
         if (eff_held)  hdr |= OUT_EFF_BIT;
         emit(hdr);
         if (note_held) begin
            emit(note_byte);
            emit(sample_byte);
         end
         if (vol_held) emit(vol_byte);
         if (eff_held) begin
            emit(eff_byte);
            emit(param_byte);
         end
         clear_flags();
         phase = PH_HEADER;
      endfunction

      function void take_header(logic [7:0] h);
         clear_flags();
         if (h == 8'h00) begin
            chan  = '0;
            phase = PH_HEADER;
            emit(8'h00);
            return;
         end
         chan       = h[4:0];
         fx_flagged = (h & IN_EFFECT_FLAG) != 0;
         if ((h & IN_NOTE_FLAG) != 0) phase = PH_NOTE;
         else if (fx_flagged) phase = PH_FX_NUM;
         else close_event();
      endfunction

      // Source effect to target effect and param
      function void map_effect(logic [7:0] num, logic [7:0] p);
         logic [4:0] sub_fx [16];
         logic [7:0] sub_base [16];
         logic [3:0] hi;
         logic [3:0] lo;
         logic [4:0] e;
         logic [7:0] q;
         sub_fx   = '{FX_S, FX_F, FX_E, FX_S, FX_S, FX_S, FX_S, FX_S,
                      FX_F, FX_E, FX_D, FX_D, FX_S, FX_S, FX_S, FX_S};
         sub_base = '{8'h00, 8'hF0, 8'hF0, 8'h10, 8'h30, 8'h20, 8'hB0, 8'h40,
                      8'hE0, 8'hE0, 8'h0F, 8'hF0, 8'hC0, 8'hD0, 8'hE0, 8'hF0};
         hi = p[7:4];
         lo = p[3:0];
         e  = FX_NONE;
         q  = p;
         case (num[4:0])
            SRC_NONE, SRC_CHANGE: e = FX_NONE;
            SRC_PORTUP: begin
               e = FX_F;
               if (p >= PARAM_LIMIT) q = PARAM_CLAMP;
            end
            SRC_PORTDN: begin
               e = FX_E;
               if (p >= PARAM_LIMIT) q = PARAM_CLAMP;
            end
            SRC_TONEPORT: e = FX_G;
            SRC_VIBRATO:  e = FX_H;
            SRC_TPVOL:    e = FX_L;
            SRC_VIBVOL:   e = FX_K;
            SRC_TREMOLO:  e = FX_R;
            SRC_TREMOR:   e = FX_I;
            SRC_OFFSET:   e = FX_O;
            SRC_VOLSLIDE: e = FX_D;
            SRC_JUMP:     e = FX_B;
            SRC_BREAK:    e = FX_C;
            SRC_EXT: begin
               // fine volume up swaps the nibble into the high half
               e = sub_fx[hi];
               if (hi == EXT_FINEVOL) q = {lo, 4'hF};
               else q = sub_base[hi] + {4'h0, lo};
            end
            SRC_SPEED:    e = FX_A;
            SRC_ARP:      e = FX_J;
            SRC_RETRIG:   e = FX_Q;
            SRC_GVOL:     e = FX_V;
            SRC_FINEVIB:  e = FX_U;
            SRC_SPECIAL: begin
               if (hi == PAN_SUB) begin
                  e = FX_S;
                  q = PAN_BASE + {4'h0, lo};
               end
            end
            SRC_TEMPO:    e = FX_T;
            default: begin
               // unassigned numbers carry nothing
               e = FX_NONE;
               q = 8'h00;
            end
         endcase
         eff_byte   = {3'b000, e};
         param_byte = q;
      endfunction

      // Accepted request: advance the parser and queue the bytes it yields
      function void note_request(req_type r);
         logic [7:0] x;
         bit         is_vol;
         x = r.in_byte;
         step_bytes.delete();
         case (phase)
            PH_NOTE: begin
               note_byte = {1'b0, x[6:0]} - 8'd1;
               phase     = PH_SAMPLE;
            end
            PH_SAMPLE: begin
               sample_byte = x;
               note_held   = 1'b1;
               if (fx_flagged) phase = PH_FX_NUM;
               else close_event();
            end
            PH_FX_NUM: begin
               // a second effect of a kind closes the event and reopens on it
               is_vol = (x[4:0] == FX_VOLUME);
               if ((is_vol && vol_held) || (!is_vol && eff_held)) begin
                  close_event();
                  take_header(x);
               end else begin
                  fx_number = x;
                  phase     = PH_FX_PARAM;
               end
            end
            PH_FX_PARAM: begin
               if (fx_number[4:0] == FX_VOLUME) begin
                  vol_held = 1'b1;
                  vol_byte = x;
               end else begin
                  eff_held = 1'b1;
                  map_effect(fx_number, x);
               end
               if ((fx_number & CHAIN_FLAG) != 0) phase = PH_FX_NUM;
               else close_event();
            end
            default: take_header(x);
         endcase
         // flush whatever is complete at pattern end
         if (r.pattern_end) begin
            if (phase != PH_HEADER) close_event();
            phase = PH_HEADER;
            clear_flags();
         end
         if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size() - 1].run_last = 1'b1;
            if (r.pattern_end) step_bytes[step_bytes.size() - 1].pattern_done = 1'b1;
         end
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result byte %02h run_last %0b pattern_done %0b",
                     $time, got.out_byte, got.run_last, got.pattern_done);
            mismatch_count++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, got.out_byte);
            mismatch_count++;
         end
         if (got.run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b, got %0b (byte %02h)",
                     $time, want.run_last, got.run_last, want.out_byte);
            mismatch_count++;
         end
         if (got.pattern_done !== want.pattern_done) begin
            $display("%0t: pattern_done expected %0b, got %0b (byte %02h)",
                     $time, want.pattern_done, got.pattern_done, want.out_byte);
            mismatch_count++;
         end
      endfunction

      function void report_leftover();
         if (expected_bytes.size() > 0) begin
            $display("%0t: %0d result bytes never arrived, oldest expected %02h",
                     $time, expected_bytes.size(), expected_bytes[0].out_byte);
            mismatch_count += expected_bytes.size();
         end
      endfunction

   endclass

endpackage

// ----- tb/tb_tracker_pattern_event_transcoder.sv -----
// ---------------------------------------------------------------------------
// tb_tracker_pattern_event_transcoder: self-checking bench for the transcoder
// Drives a directed byte sequence and then random well-formed events, broken
// events and noise through the request queue in bursts, while the result side
// stalls in changing patterns; every result byte is checked against a model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tracker_pattern_event_transcoder;

   import tpet_pkg::*;
   import tb_tpet_scoreboard_pkg::*;

   typedef enum int {
      RX_STREAM     = 0,
      RX_RANDOM     = 1,
      RX_SPARSE     = 2,
      RX_LONG_STALL = 3
   } stall_mode_e;

   localparam int RANDOM_ITEMS_END = 255;

   // Directed requests: {in_byte, pattern_end}
   localparam logic [8:0] DIRECTED_SEQ [25] = '{
      // zero header, then header bit 7 with channel only
      {8'h00, 1'b0}, {8'h9F, 1'b0},
      // note wraps to FF, chained volume, port up param clamped
      {8'h65, 1'b0}, {8'h80, 1'b0}, {8'hFF, 1'b0}, {8'h2C, 1'b0},
      {8'h40, 1'b0}, {8'h01, 1'b0}, {8'hE5, 1'b0},
      // effect only, extended fine volume up
      {8'h43, 1'b0}, {8'h0E, 1'b0}, {8'hA7, 1'b0},
      // second non-volume effect is reread as a header
      {8'h41, 1'b0}, {8'h21, 1'b0}, {8'h10, 1'b0}, {8'h02, 1'b0},
      // unassigned effect number
      {8'h41, 1'b0}, {8'h17, 1'b0}, {8'h33, 1'b0},
      // special effect with pan sub-effect
      {8'h41, 1'b0}, {8'h1E, 1'b0}, {8'h85, 1'b0},
      // pattern ends inside the note pair, then zero header at pattern end
      {8'h62, 1'b0}, {8'h05, 1'b1}, {8'h00, 1'b1}
   };

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    push        = 1'b0;
   logic    pop         = 1'b0;
   req_type req_payload = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_payload;

   int          burst_left = 0;
   int          items_sent = 0;
   int          rx_cycle   = 0;
   stall_mode_e rx_mode    = RX_STREAM;

   event_transcode_scoreboard sb = new();

   tracker_pattern_event_transcoder DUT (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Note each request as it is accepted
   always @(posedge clock) begin
      if (!reset && push && !full) sb.note_request(req_payload);
   end

   // Check accepted results; pop follows a stall pattern that is redrawn at random
   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_result(rsp_payload);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = stall_mode_e'($urandom_range(0, 3));
      case (rx_mode)
         RX_STREAM:     pop <= 1'b1;
         RX_RANDOM:     pop <= 1'($urandom_range(0, 1));
         RX_SPARSE:     pop <= (rx_cycle % 4 == 0);
         RX_LONG_STALL: pop <= (rx_cycle % 16 >= 12);
         default:       pop <= 1'b1;
      endcase
   end

   // One request; bursts of random length separated by random gaps
   task automatic send_request(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 10);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      push                    <= 1'b1;
      req_payload.in_byte     <= b;
      req_payload.pattern_end <= last;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endtask

   // Well-formed event with random content; sometimes cut short at pattern end
   task automatic send_event();
      logic [7:0] seq[$];
      logic [7:0] num;
      logic [7:0] param;
      logic [4:0] num_lo;
      int         npairs;
      int         cut;
      bit         want_note;
      bit         want_fx;
      bit         dup_mode;
      bit         have_vol;
      bit         have_eff;
      bit         use_vol;
      bit         finish_pattern;
      want_note = $urandom_range(0, 2) != 0;
      want_fx   = $urandom_range(0, 3) != 0;
      dup_mode  = $urandom_range(0, 5) == 0;
      have_vol  = 1'b0;
      have_eff  = 1'b0;
      if ($urandom_range(0, 11) == 0) seq.push_back(8'h00);
      else seq.push_back({1'($urandom_range(0, 1)), want_fx, want_note,
                          5'($urandom_range(0, 31))});
      if (seq[0] != 8'h00 && want_note) begin
         seq.push_back(8'($urandom_range(0, 255)));
         seq.push_back(8'($urandom_range(0, 255)));
      end
      if (seq[0] != 8'h00 && want_fx) begin
         npairs = dup_mode ? 3 : $urandom_range(1, 2);
         for (int i = 0; i < npairs; i++) begin
            if ((!have_vol && !have_eff) || dup_mode) use_vol = $urandom_range(0, 1);
            else use_vol = !have_vol;
            if (use_vol) begin
               num_lo = FX_VOLUME;
            end else begin
               case ($urandom_range(0, 5))
                  0:       num_lo = SRC_EXT;
                  1:       num_lo = SRC_SPECIAL;
                  2:       num_lo = $urandom_range(0, 1) ? SRC_PORTUP : SRC_PORTDN;
                  default: num_lo = 5'($urandom_range(0, 31));
               endcase
               if (num_lo == FX_VOLUME) num_lo = SRC_TEMPO;
            end
            num   = {2'($urandom_range(0, 3)), i < npairs - 1, num_lo};
            param = 8'($urandom_range(0, 255));
            if ((num_lo == SRC_PORTUP || num_lo == SRC_PORTDN) && $urandom_range(0, 1))
               param = 8'($urandom_range(224, 255));
            if (num_lo == SRC_SPECIAL && $urandom_range(0, 1))
               param = {PAN_SUB, 4'($urandom_range(0, 15))};
            seq.push_back(num);
            seq.push_back(param);
            have_vol |= use_vol;
            have_eff |= !use_vol;
         end
      end
      finish_pattern = $urandom_range(0, 5) == 0;
      if (seq.size() > 1 && $urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, seq.size() - 1);
         while (seq.size() > cut) void'(seq.pop_back());
         finish_pattern = 1'b1;
      end
      foreach (seq[i]) send_request(seq[i], finish_pattern && i == seq.size() - 1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SEQ[i]) send_request(DIRECTED_SEQ[i][8:1], DIRECTED_SEQ[i][0]);

      // mostly well-formed events, some noise
      while (items_sent < RANDOM_ITEMS_END) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_event();
      end
      push <= 1'b0;

      // drain, then allow for any stray bytes
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      sb.report_leftover();
      if (sb.mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
